@@ sv/segx_pkg.sv @@
// Shared widths, types and constants for the segment intersection pipeline.
package segx_pkg;

  // Coordinate and fixed-point configuration.
  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 8;
  localparam int OUT_W         = 24;

  // Derived widths.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int QUO_W   = COORD_BITS + FRACTION_BITS;
  localparam int NUM_W   = CROSS_W + QUO_W;
  localparam int SUM_W   = (QUO_W + 2 > OUT_W + 1) ? QUO_W + 2 : OUT_W + 1;

  // Pipeline depth from an accepted item to its result strobe being taken.
  localparam int LATENCY = QUO_W + 6;

  // Saturation limits of the output coordinates.
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Side information that travels with one coordinate through the divider.
  typedef struct packed {
    logic                         hit;
    logic                         neg;
    logic signed [COORD_BITS-1:0] start;
  } coord_tag_t;

  // Operands of one coordinate's offset division.
  typedef struct packed {
    logic [CROSS_W-1:0]    tn_mag;
    logic [COORD_BITS-1:0] edge_mag;
    logic [CROSS_W-1:0]    den_mag;
    coord_tag_t            tag;
  } div_in_t;

endpackage

@@ sv/segx_cross.sv @@
// Front end: edge differences, cross products, hit test and operand magnitudes.
module segx_cross (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [segx_pkg::COORD_BITS-1:0] psx,
  input  logic signed [segx_pkg::COORD_BITS-1:0] psy,
  input  logic signed [segx_pkg::COORD_BITS-1:0] pex,
  input  logic signed [segx_pkg::COORD_BITS-1:0] pey,
  input  logic signed [segx_pkg::COORD_BITS-1:0] qsx,
  input  logic signed [segx_pkg::COORD_BITS-1:0] qsy,
  input  logic signed [segx_pkg::COORD_BITS-1:0] qex,
  input  logic signed [segx_pkg::COORD_BITS-1:0] qey,
  output logic                                   out_valid,
  output segx_pkg::div_in_t                      div_x,
  output segx_pkg::div_in_t                      div_y
);

  localparam int CW = segx_pkg::COORD_BITS;
  localparam int DW = segx_pkg::DIFF_W;
  localparam int PW = segx_pkg::PROD_W;
  localparam int XW = segx_pkg::CROSS_W;

  // Stage 1: differences.
  logic                 s1_valid;
  logic signed [DW-1:0] ax1, ay1, bx1, by1, cx1, cy1;
  logic signed [CW-1:0] psx1, psy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    ax1  <= DW'(pex) - DW'(psx);
    ay1  <= DW'(pey) - DW'(psy);
    bx1  <= DW'(qex) - DW'(qsx);
    by1  <= DW'(qey) - DW'(qsy);
    cx1  <= DW'(psx) - DW'(qsx);
    cy1  <= DW'(psy) - DW'(qsy);
    psx1 <= psx;
    psy1 <= psy;
  end

  // Stage 2: the six cross-product terms.
  logic                 s2_valid;
  logic signed [PW-1:0] pd0, pd1, ps0, ps1, pt0, pt1;
  logic signed [DW-1:0] ax2, ay2;
  logic signed [CW-1:0] psx2, psy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    pd0  <= PW'(ax1) * PW'(by1);
    pd1  <= PW'(bx1) * PW'(ay1);
    ps0  <= PW'(ax1) * PW'(cy1);
    ps1  <= PW'(ay1) * PW'(cx1);
    pt0  <= PW'(bx1) * PW'(cy1);
    pt1  <= PW'(by1) * PW'(cx1);
    ax2  <= ax1;
    ay2  <= ay1;
    psx2 <= psx1;
    psy2 <= psy1;
  end

  // Stage 3: denominator and both numerators.
  logic                 s3_valid;
  logic signed [XW-1:0] den3, sn3, tn3;
  logic signed [DW-1:0] ax3, ay3;
  logic signed [CW-1:0] psx3, psy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    den3 <= XW'(pd0) - XW'(pd1);
    sn3  <= XW'(ps0) - XW'(ps1);
    tn3  <= XW'(pt0) - XW'(pt1);
    ax3  <= ax2;
    ay3  <= ay2;
    psx3 <= psx2;
    psy3 <= psy2;
  end

  // Stage 4: parameter range test by sign and magnitude, then magnitudes.
  logic          s_ok, t_ok, hit4;
  logic [XW-1:0] den_mag, tn_mag;
  logic [DW-1:0] ax_abs, ay_abs;

  always_comb begin
    if (den3 > 0) begin
      s_ok = (sn3 >= 0) && (sn3 <= den3);
      t_ok = (tn3 >= 0) && (tn3 <= den3);
    end else begin
      s_ok = (sn3 <= 0) && (sn3 >= den3);
      t_ok = (tn3 <= 0) && (tn3 >= den3);
    end
    hit4    = (den3 != 0) && s_ok && t_ok;
    den_mag = den3[XW-1] ? XW'(-den3) : XW'(den3);
    tn_mag  = tn3[XW-1] ? XW'(-tn3) : XW'(tn3);
    ax_abs  = ax3[DW-1] ? DW'(-ax3) : DW'(ax3);
    ay_abs  = ay3[DW-1] ? DW'(-ay3) : DW'(ay3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_valid;
    end
    div_x.tn_mag    <= tn_mag;
    div_x.edge_mag  <= ax_abs[CW-1:0];
    div_x.den_mag   <= den_mag;
    div_x.tag.hit   <= hit4;
    div_x.tag.neg   <= tn3[XW-1] ^ ax3[DW-1] ^ den3[XW-1];
    div_x.tag.start <= psx3;
    div_y.tn_mag    <= tn_mag;
    div_y.edge_mag  <= ay_abs[CW-1:0];
    div_y.den_mag   <= den_mag;
    div_y.tag.hit   <= hit4;
    div_y.tag.neg   <= tn3[XW-1] ^ ay3[DW-1] ^ den3[XW-1];
    div_y.tag.start <= psy3;
  end

endmodule

@@ sv/segx_div_step.sv @@
// One restoring division step: produces one quotient bit per pipeline stage.
module segx_div_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [segx_pkg::CROSS_W-1:0]      in_rem,
  input  logic [segx_pkg::QUO_W-1:0]        in_low,
  input  logic [segx_pkg::CROSS_W-1:0]      in_den,
  input  segx_pkg::coord_tag_t              in_tag,
  output logic                              out_valid,
  output logic [segx_pkg::CROSS_W-1:0]      out_rem,
  output logic [segx_pkg::QUO_W-1:0]        out_low,
  output logic [segx_pkg::CROSS_W-1:0]      out_den,
  output segx_pkg::coord_tag_t              out_tag
);

  localparam int XW = segx_pkg::CROSS_W;
  localparam int QW = segx_pkg::QUO_W;

  // The low word shifts the next dividend bit out at its top and takes the
  // quotient bit in at its bottom.
  logic [XW:0]   trial;
  logic          ge;
  logic [XW:0]   diff;
  logic [XW-1:0] rem_next;

  always_comb begin
    trial    = {in_rem, in_low[QW-1]};
    ge       = trial >= {1'b0, in_den};
    diff     = trial - {1'b0, in_den};
    rem_next = ge ? diff[XW-1:0] : trial[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem <= rem_next;
    out_low <= {in_low[QW-2:0], ge};
    out_den <= in_den;
    out_tag <= in_tag;
  end

endmodule

@@ sv/segx_divider.sv @@
// Pipelined offset divider: magnitude product, then one quotient bit per stage.
module segx_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  segx_pkg::div_in_t             in_op,
  output logic                          out_valid,
  output logic [segx_pkg::QUO_W-1:0]    quo,
  output segx_pkg::coord_tag_t          out_tag
);

  localparam int XW = segx_pkg::CROSS_W;
  localparam int QW = segx_pkg::QUO_W;
  localparam int NW = segx_pkg::NUM_W;
  localparam int MW = segx_pkg::CROSS_W + segx_pkg::COORD_BITS;

  // Multiply stage. The scaled numerator is below den * 2^QUO_W on a hit, so
  // its top CROSS_W bits start the remainder already below the divisor.
  logic [MW-1:0] prod;
  logic [NW-1:0] num;

  always_comb begin
    prod = MW'(in_op.tn_mag) * MW'(in_op.edge_mag);
    num  = NW'(prod) << segx_pkg::FRACTION_BITS;
  end

  logic                 v_st   [QW+1];
  logic [XW-1:0]        rem_st [QW+1];
  logic [QW-1:0]        low_st [QW+1];
  logic [XW-1:0]        den_st [QW+1];
  segx_pkg::coord_tag_t tag_st [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_st[0] <= 1'b0;
    end else begin
      v_st[0] <= in_valid;
    end
    rem_st[0] <= num[NW-1 -: XW];
    low_st[0] <= num[QW-1:0];
    den_st[0] <= in_op.den_mag;
    tag_st[0] <= in_op.tag;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    segx_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_st[i]),
      .in_rem    (rem_st[i]),
      .in_low    (low_st[i]),
      .in_den    (den_st[i]),
      .in_tag    (tag_st[i]),
      .out_valid (v_st[i+1]),
      .out_rem   (rem_st[i+1]),
      .out_low   (low_st[i+1]),
      .out_den   (den_st[i+1]),
      .out_tag   (tag_st[i+1])
    );
  end

  // The final remainder is not needed; only the quotient leaves.
  logic rem_zero;
  assign rem_zero  = (rem_st[QW] == '0);
  assign out_valid = v_st[QW] | (v_st[QW] & rem_zero);
  assign quo       = low_st[QW];
  assign out_tag   = tag_st[QW];

endmodule

@@ sv/segment_intersection.sv @@
// Top level of the pipelined segment intersection block.
//
// Usage: drive the two segments' endpoints on the coordinate ports and raise
// start for one cycle per item. An item is accepted at a rising edge where
// start is high and busy is low. Busy is high only in the cycle after a reset
// cycle, so after reset a new item may be accepted at every clock edge.
//
// Each item produces exactly one result. It appears on hit, cross_x and
// cross_y for one cycle, marked by done, and is taken at the edge ending that
// cycle. Results are taken in input order. Throughput is one item per cycle;
// the depth is set by the bit-serial restoring divider, which resolves one
// quotient bit per stage, plus six stages for differences, products, cross
// terms, range test, the magnitude product and the output offset and
// saturation.
//
// The receiver cannot hold results off, and the pipeline never stalls.
// Reset clears every valid bit, so items in flight are dropped and no done
// strobe appears until new items have passed through.
module segment_intersection (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_y,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [segx_pkg::OUT_W-1:0]      cross_x,
  output logic signed [segx_pkg::OUT_W-1:0]      cross_y
);

  localparam int QW = segx_pkg::QUO_W;
  localparam int SW = segx_pkg::SUM_W;
  localparam int OW = segx_pkg::OUT_W;

  // Busy covers the cycle right after reset so that nothing is accepted
  // while the pipeline's valid bits are still being cleared.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // Front end: differences, cross products and the hit decision.
  logic              cross_valid;
  segx_pkg::div_in_t div_x, div_y;

  segx_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .psx       (first_start_x),
    .psy       (first_start_y),
    .pex       (first_end_x),
    .pey       (first_end_y),
    .qsx       (second_start_x),
    .qsy       (second_start_y),
    .qex       (second_end_x),
    .qey       (second_end_y),
    .out_valid (cross_valid),
    .div_x     (div_x),
    .div_y     (div_y)
  );

  // One divider per coordinate; both run in lockstep.
  logic                 vx, vy;
  logic [QW-1:0]        qx, qy;
  segx_pkg::coord_tag_t tx, ty;

  segx_divider u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_op     (div_x),
    .out_valid (vx),
    .quo       (qx),
    .out_tag   (tx)
  );

  segx_divider u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_op     (div_y),
    .out_valid (vy),
    .quo       (qy),
    .out_tag   (ty)
  );

  // Applies the sign to the truncated quotient, adds the scaled start point
  // and clamps to the output range. A miss gives zero.
  function automatic logic signed [OW-1:0] place(segx_pkg::coord_tag_t tag,
                                                 logic [QW-1:0] q);
    logic signed [QW:0]   off;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat;
    off  = tag.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    base = SW'(tag.start) <<< segx_pkg::FRACTION_BITS;
    sum  = base + SW'(off);
    if (sum > segx_pkg::SAT_HI) begin
      sat = segx_pkg::SAT_HI;
    end else if (sum < segx_pkg::SAT_LO) begin
      sat = segx_pkg::SAT_LO;
    end else begin
      sat = sum;
    end
    if (!tag.hit) begin
      sat = '0;
    end
    return sat[OW-1:0];
  endfunction

  logic                 hit_next;
  logic signed [OW-1:0] cross_x_next, cross_y_next;

  always_comb begin
    hit_next     = tx.hit;
    cross_x_next = place(tx, qx);
    cross_y_next = place(ty, qy);
  end

  // Output register: one strobe per item, payload loaded alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vx && vy;
    end
    hit     <= hit_next;
    cross_x <= cross_x_next;
    cross_y <= cross_y_next;
  end

endmodule

@@ sv/segx_checker.sv @@
// Port-level checker for the segment intersection block, with its bind.
module segx_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   done,
  input logic                                   hit,
  input logic signed [segx_pkg::OUT_W-1:0]      cross_x,
  input logic signed [segx_pkg::OUT_W-1:0]      cross_y
);

  // Every accepted item yields its result after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(segx_pkg::LATENCY) done)
    else $error("accepted item produced no result at the expected cycle");

  // A result strobe only follows an accepted item.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, segx_pkg::LATENCY))
    else $error("result strobe without a matching accepted item");

  // A miss reports the origin as its point.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (cross_x == '0) && (cross_y == '0))
    else $error("miss reported a nonzero crossing point");

  // Reset flushes the pipeline and blocks intake for a cycle.
  a_reset: assert property (@(posedge clk)
    rst |=> (!done && busy))
    else $error("pipeline not flushed by reset");

endmodule

bind segment_intersection segx_checker u_segx_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .hit     (hit),
  .cross_x (cross_x),
  .cross_y (cross_y)
);
